// File: src/b64d_pkg.sv
package b64d_pkg;

    // Symbol value for every byte outside the alphabet ('=', whitespace, junk)
    localparam logic [6:0] SYM_NONE = 7'd64;

    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHR_LO_A  = 8'h61;
    localparam logic [7:0] CHR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHR_DIG_0 = 8'h30;
    localparam logic [7:0] CHR_DIG_9 = 8'h39;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_SLASH = 8'h2F;

    localparam logic [7:0] OFS_LO  = 8'd26;
    localparam logic [7:0] OFS_DIG = 8'd52;
    localparam logic [6:0] SYM_PLUS  = 7'd62;
    localparam logic [6:0] SYM_SLASH = 7'd63;

    // Input word: one encoded character
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_in_word;

    // Output word: one decoded byte
    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_of_group;
    } t_out_word;

    // One completed group: bytes packed to the front, count of 1 to 3
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      n_bytes;
    } t_group;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Map a character to its 7-bit symbol value
    function automatic logic [6:0] map_symbol(input logic [7:0] c);
        logic [7:0] v;
        v = {1'b0, SYM_NONE};
        if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
            v = c - CHR_UP_A;
        end else if (c >= CHR_LO_A && c <= CHR_LO_Z) begin
            v = c - CHR_LO_A + OFS_LO;
        end else if (c >= CHR_DIG_0 && c <= CHR_DIG_9) begin
            v = c - CHR_DIG_0 + OFS_DIG;
        end else if (c == CHR_PLUS) begin
            v = {1'b0, SYM_PLUS};
        end else if (c == CHR_SLASH) begin
            v = {1'b0, SYM_SLASH};
        end
        return v[6:0];
    endfunction

endpackage

// File: src/b64d_front.sv
module b64d_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  b64d_pkg::t_in_word i_in_word,
    output logic               o_in_ready,
    input  b64d_pkg::t_q_stat  i_q_stat,
    output logic               o_push,
    output b64d_pkg::t_group   o_group
);
    import b64d_pkg::*;

    logic [1:0] r_count, n_count;
    logic [2:0][6:0] r_held;
    logic [6:0] sym;
    logic       accept;
    logic [7:0] b0, b1, b2;
    logic       s2_ok, s3_ok;

    // Only the fourth symbol needs room in the queue
    assign o_in_ready = (r_count != 2'd3) || !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;
    assign sym        = map_symbol(i_in_word.char_in);

    // Byte assembly from the three held symbols and the current one
    assign b0 = {r_held[0][5:0], 2'b00} + {5'd0, r_held[1][6:4]};
    assign b1 = {r_held[1][3:0], 4'b0000} + {3'd0, r_held[2][6:2]};
    assign b2 = {r_held[2][1:0], 6'd0} + {1'b0, sym};
    assign s2_ok = (r_held[2] != SYM_NONE);
    assign s3_ok = (sym != SYM_NONE);

    always_comb begin
        o_push          = accept && (r_count == 2'd3);
        o_group.bytes[0] = b0;
        o_group.bytes[1] = s2_ok ? b1 : b2;
        o_group.bytes[2] = b2;
        o_group.n_bytes  = 2'd1 + {1'b0, s2_ok} + {1'b0, s3_ok};
    end

    // Symbol counter, cleared at group end and at end of input
    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = (r_count == 2'd3) ? 2'd0 : r_count + 2'd1;
            if (i_in_word.end_of_input) begin
                n_count = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_held  <= '0;
        end else begin
            r_count <= n_count;
            if (accept && r_count != 2'd3) begin
                r_held[r_count] <= sym;
            end
        end
    end

endmodule

// File: src/b64d_queue.sv
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64d_pkg::t_group  i_group,
    input  logic              i_pop,
    output b64d_pkg::t_group  o_head,
    output b64d_pkg::t_q_stat o_stat
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("group pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("fill count lost a push");

endmodule

// File: src/b64d_back.sv
module b64d_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64d_pkg::t_group    i_head,
    input  b64d_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    output b64d_pkg::t_out_word o_out_word,
    input  logic                i_out_ready
);
    import b64d_pkg::*;

    logic [1:0] r_idx;
    logic       last;
    logic       accept;

    // Walk the bytes of the head group, one per accepted word
    assign last        = ((r_idx + 2'd1) == i_head.n_bytes);
    assign o_out_valid = !i_q_stat.empty;
    assign accept      = o_out_valid && i_out_ready;
    assign o_pop       = accept && last;

    always_comb begin
        o_out_word.byte_out      = i_head.bytes[r_idx];
        o_out_word.last_of_group = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (accept) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

// File: src/base64_stream_decoder_top.sv
// A group enters the queue with its fourth character; its bytes are read from the head.
// Throughput: one character per cycle; a group gives 1 to 3 bytes, one per i_out_ready cycle.
// The input stalls only on a group-completing character while the group queue is full.
// The queue holds QUEUE_DEPTH groups between the decoder front and the byte serializer.
// Reset (synchronous, active low) clears symbol count, held symbols and the queue.
module base64_stream_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  b64d_pkg::t_in_word  i_in_word,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output b64d_pkg::t_out_word o_out_word,
    input  logic                i_out_ready
);
    import b64d_pkg::*;

    t_group  push_group, head_group;
    t_q_stat q_stat;
    logic    push, pop;

    // Character intake and group assembly
    b64d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_ready (o_in_ready),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_group    (push_group)
    );

    // Group queue
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_group),
        .i_pop   (pop),
        .o_head  (head_group),
        .o_stat  (q_stat)
    );

    // Byte serializer
    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_group),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

endmodule
